// ===== sv/prsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the picture-unit register and scroll unit.
// Used by the top level; no dependencies.

package prsu_pkg;

   // Store sizes
   localparam int OAM_DEPTH = 256;
   localparam int PAL_DEPTH = 32;
   localparam int OAM_AW    = $clog2(OAM_DEPTH);
   localparam int PAL_AW    = $clog2(PAL_DEPTH);

   // Item operation codes
   typedef enum logic [3:0] {
      OP_REG_WRITE   = 4'd0,
      OP_REG_READ    = 4'd1,
      OP_READ_FILL   = 4'd2,
      OP_DMA_BYTE    = 4'd3,
      OP_INC_X       = 4'd4,
      OP_INC_Y       = 4'd5,
      OP_COPY_X      = 4'd6,
      OP_COPY_Y      = 4'd7,
      OP_VBLANK      = 4'd8,
      OP_FRAME_START = 4'd9,
      OP_SPRITE0_HIT = 4'd10,
      OP_OVERFLOW    = 4'd11,
      OP_OAM_CLEAR   = 4'd12
   } op_type;

   // Register indexes
   localparam logic [2:0] REG_CTRL    = 3'd0;
   localparam logic [2:0] REG_MASK    = 3'd1;
   localparam logic [2:0] REG_STATUS  = 3'd2;
   localparam logic [2:0] REG_OAMADDR = 3'd3;
   localparam logic [2:0] REG_OAMDATA = 3'd4;
   localparam logic [2:0] REG_SCROLL  = 3'd5;
   localparam logic [2:0] REG_ADDR    = 3'd6;
   localparam logic [2:0] REG_DATA    = 3'd7;

   // Scroll address masks
   localparam logic [14:0] COPY_X_MASK = 15'h041F;
   localparam logic [14:0] COPY_Y_MASK = 15'h7BE0;
   localparam logic [14:0] NT_X_BIT    = 15'h0400;
   localparam logic [5:0]  PAL_PAGE    = 6'h3F;
   localparam logic [13:0] PAL_REFILL  = 14'h1000;
   localparam logic [7:0]  GRAY_MASK   = 8'h30;

   // Read data source for the response stage
   typedef enum logic [1:0] {
      RD_FIXED = 2'd0,
      RD_OAM   = 2'd1,
      RD_PAL   = 2'd2
   } rd_sel_type;

   // Result fields, in bus order
   typedef struct packed {
      logic [7:0]  mask_bits;
      logic        tall_sprites;
      logic        sprite_table_high;
      logic        bg_table_high;
      logic [2:0]  fine_scroll_x;
      logic [14:0] current_addr;
      logic [7:0]  vram_wdata;
      logic [13:0] vram_addr;
      logic        vram_write;
      logic        vram_read;
      logic        nmi_pulse;
      logic [7:0]  read_data;
   } rsp_type;

   // Item in flight between accept and the result register
   typedef struct packed {
      rd_sel_type rd_sel;
      logic       gray;
      rsp_type    rsp;
   } stage_type;

endpackage

// ===== sv/ppu_register_scroll_unit_top.sv =====
`timescale 1ns / 1ps
// Picture-unit register file with scroll counters, OAM and palette stores.
// Depends on prsu_pkg and prsu_ram.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  req     | in  | req_tvalid/tready  | tuser: op; tdata: reg_index, value, dma
//  rsp     | out | rsp_tvalid/tready  | tdata: read_data .. mask_bits (64 bits)
//
// One item per clock sustained while rsp_tready stays high; a result passes
// through stage one and the result register, a depth set by the registered read of the OAM and palette RAMs.
// Register state and RAM writes update at the accept edge; the RAM read data
// joins the item in the second stage, then the result register holds it.
// Reset (synchronous, high) clears all architectural register state and the valid flags; RAM contents are kept.
// A stalled result holds stage two; req_tready drops only when both are full.

module ppu_register_scroll_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [3:0]  req_tuser,  // [3:0] op
   input  logic [23:0] req_tdata,  // [2:0] reg_index, [10:3] value, [18:11] dma_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] nmi_pulse, [9] vram_read, [10] vram_write,
   // [24:11] vram_addr, [32:25] vram_wdata, [47:33] current_addr,
   // [50:48] fine_scroll_x, [51] bg_table_high, [52] sprite_table_high,
   // [53] tall_sprites, [61:54] mask_bits
   output logic [63:0] rsp_tdata
);

   // Architectural state
   logic        nmi_enable_ff, nmi_enable_in;
   logic        step32_ff, step32_in;
   logic        bg_sel_ff, bg_sel_in;
   logic        spr_sel_ff, spr_sel_in;
   logic        tall_ff, tall_in;
   logic [7:0]  mask_ff, mask_in;
   logic [14:0] temp_ff, temp_in;
   logic [14:0] cur_ff, cur_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic        toggle_ff, toggle_in;
   logic        vblank_ff, vblank_in;
   logic        hit_ff, hit_in;
   logic        ovf_ff, ovf_in;
   logic [prsu_pkg::OAM_AW-1:0] oam_ptr_ff, oam_ptr_in;
   logic [7:0]  rbuf_ff, rbuf_in;

   // Pipeline
   logic                s1_vld_ff, s1_vld_in;
   prsu_pkg::stage_type s1_ff, s1_in;
   logic                out_vld_ff, out_vld_in;
   prsu_pkg::rsp_type   out_ff, out_in;
   logic                accept, s1_move;

   // Decoded item
   prsu_pkg::op_type op;
   logic [2:0]       reg_idx;
   logic [7:0]       val;
   logic [7:0]       dma_idx;

   // RAM ports
   logic                        oam_we, oam_re;
   logic [prsu_pkg::OAM_AW-1:0] oam_waddr;
   logic [7:0]                  oam_rdata;
   logic                        pal_we, pal_re;
   logic [prsu_pkg::PAL_AW-1:0] pal_slot;
   logic [7:0]                  pal_rdata;

   // Helpers
   logic [13:0] data_addr;
   logic        in_pal;
   logic [14:0] cur_step;
   logic [4:0]  coarse_y;

   assign op      = prsu_pkg::op_type'(req_tuser[3:0]);
   assign reg_idx = req_tdata[2:0];
   assign val     = req_tdata[10:3];
   assign dma_idx = req_tdata[18:11];

   // Handshake
   assign s1_move    = s1_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   // Data port address, palette slot with mirroring of the backdrop entries
   assign data_addr = cur_ff[13:0];
   assign in_pal    = (data_addr[13:8] == prsu_pkg::PAL_PAGE);
   assign cur_step  = cur_ff + (step32_ff ? 15'd32 : 15'd1);
   always_comb begin
      pal_slot = data_addr[prsu_pkg::PAL_AW-1:0];
      if (pal_slot[1:0] == 2'b00) begin
         pal_slot[4] = 1'b0;
      end
   end

   // Next state, RAM requests and stage-one contents
   always_comb begin
      nmi_enable_in = nmi_enable_ff;
      step32_in     = step32_ff;
      bg_sel_in     = bg_sel_ff;
      spr_sel_in    = spr_sel_ff;
      tall_in       = tall_ff;
      mask_in       = mask_ff;
      temp_in       = temp_ff;
      cur_in        = cur_ff;
      fine_x_in     = fine_x_ff;
      toggle_in     = toggle_ff;
      vblank_in     = vblank_ff;
      hit_in        = hit_ff;
      ovf_in        = ovf_ff;
      oam_ptr_in    = oam_ptr_ff;
      rbuf_in       = rbuf_ff;
      oam_we        = 1'b0;
      oam_re        = 1'b0;
      oam_waddr     = oam_ptr_ff;
      pal_we        = 1'b0;
      pal_re        = 1'b0;
      coarse_y      = 5'd0;
      s1_in         = '0;
      s1_in.rd_sel  = prsu_pkg::RD_FIXED;
      s1_in.gray    = mask_ff[0];

      case (op)
         prsu_pkg::OP_REG_WRITE: begin
            case (reg_idx)
               prsu_pkg::REG_CTRL: begin
                  s1_in.rsp.nmi_pulse = !nmi_enable_ff && val[7] && vblank_ff;
                  nmi_enable_in       = val[7];
                  step32_in           = val[2];
                  bg_sel_in           = val[4];
                  spr_sel_in          = val[3];
                  tall_in             = val[5];
                  temp_in[11:10]      = val[1:0];
               end
               prsu_pkg::REG_MASK: begin
                  mask_in = val;
               end
               prsu_pkg::REG_OAMADDR: begin
                  oam_ptr_in = val;
               end
               prsu_pkg::REG_OAMDATA: begin
                  oam_we     = 1'b1;
                  oam_ptr_in = oam_ptr_ff + 8'd1;
               end
               prsu_pkg::REG_SCROLL: begin
                  if (!toggle_ff) begin
                     temp_in[4:0] = val[7:3];
                     fine_x_in    = val[2:0];
                  end else begin
                     temp_in[14:12] = val[2:0];
                     temp_in[9:5]   = val[7:3];
                  end
                  toggle_in = !toggle_ff;
               end
               prsu_pkg::REG_ADDR: begin
                  if (!toggle_ff) begin
                     temp_in[13:8] = val[5:0];
                     temp_in[14]   = 1'b0;
                  end else begin
                     temp_in[7:0] = val;
                     cur_in       = {temp_ff[14:8], val};
                  end
                  toggle_in = !toggle_ff;
               end
               prsu_pkg::REG_DATA: begin
                  if (in_pal) begin
                     pal_we = 1'b1;
                  end else begin
                     s1_in.rsp.vram_write = 1'b1;
                     s1_in.rsp.vram_addr  = data_addr;
                     s1_in.rsp.vram_wdata = val;
                  end
                  cur_in = cur_step;
               end
               default: begin
               end
            endcase
         end
         prsu_pkg::OP_REG_READ: begin
            case (reg_idx)
               prsu_pkg::REG_STATUS: begin
                  s1_in.rsp.read_data = {vblank_ff, hit_ff, ovf_ff, 5'd0};
                  toggle_in           = 1'b0;
                  vblank_in           = 1'b0;
               end
               prsu_pkg::REG_OAMDATA: begin
                  oam_re       = 1'b1;
                  s1_in.rd_sel = prsu_pkg::RD_OAM;
               end
               prsu_pkg::REG_DATA: begin
                  s1_in.rsp.vram_read = 1'b1;
                  if (in_pal) begin
                     pal_re              = 1'b1;
                     s1_in.rd_sel        = prsu_pkg::RD_PAL;
                     s1_in.rsp.vram_addr = data_addr - prsu_pkg::PAL_REFILL;
                  end else begin
                     s1_in.rsp.read_data = rbuf_ff;
                     s1_in.rsp.vram_addr = data_addr;
                  end
                  cur_in = cur_step;
               end
               default: begin
               end
            endcase
         end
         prsu_pkg::OP_READ_FILL: begin
            rbuf_in = val;
         end
         prsu_pkg::OP_DMA_BYTE: begin
            oam_we    = 1'b1;
            oam_waddr = oam_ptr_ff + dma_idx;
         end
         prsu_pkg::OP_INC_X: begin
            // Wrap coarse X into the neighbouring nametable
            if (cur_ff[4:0] == 5'd31) begin
               cur_in = {cur_ff[14:5], 5'd0} ^ prsu_pkg::NT_X_BIT;
            end else begin
               cur_in = cur_ff + 15'd1;
            end
         end
         prsu_pkg::OP_INC_Y: begin
            // Fine Y first, then coarse Y with row 29 flipping the nametable
            if (cur_ff[14:12] != 3'd7) begin
               cur_in[14:12] = cur_ff[14:12] + 3'd1;
            end else begin
               cur_in[14:12] = 3'd0;
               case (cur_ff[9:5])
                  5'd29: begin
                     coarse_y   = 5'd0;
                     cur_in[11] = !cur_ff[11];
                  end
                  5'd31: begin
                     coarse_y = 5'd0;
                  end
                  default: begin
                     coarse_y = cur_ff[9:5] + 5'd1;
                  end
               endcase
               cur_in[9:5] = coarse_y;
            end
         end
         prsu_pkg::OP_COPY_X: begin
            cur_in = (cur_ff & prsu_pkg::COPY_Y_MASK) | (temp_ff & prsu_pkg::COPY_X_MASK);
         end
         prsu_pkg::OP_COPY_Y: begin
            cur_in = (cur_ff & prsu_pkg::COPY_X_MASK) | (temp_ff & prsu_pkg::COPY_Y_MASK);
         end
         prsu_pkg::OP_VBLANK: begin
            s1_in.rsp.nmi_pulse = nmi_enable_ff;
            vblank_in           = 1'b1;
         end
         prsu_pkg::OP_FRAME_START: begin
            vblank_in = 1'b0;
            hit_in    = 1'b0;
            ovf_in    = 1'b0;
         end
         prsu_pkg::OP_SPRITE0_HIT: begin
            hit_in = 1'b1;
         end
         prsu_pkg::OP_OVERFLOW: begin
            ovf_in = 1'b1;
         end
         prsu_pkg::OP_OAM_CLEAR: begin
            oam_ptr_in = '0;
         end
         default: begin
         end
      endcase

      // State after the item
      s1_in.rsp.current_addr      = cur_in;
      s1_in.rsp.fine_scroll_x     = fine_x_in;
      s1_in.rsp.bg_table_high     = bg_sel_in;
      s1_in.rsp.sprite_table_high = spr_sel_in;
      s1_in.rsp.tall_sprites      = tall_in;
      s1_in.rsp.mask_bits         = mask_in;
   end

   // Stores
   prsu_ram #(.WIDTH(8), .DEPTH(prsu_pkg::OAM_DEPTH)) u_oam_ram (
      .clock   (clock),
      .wr_en   (accept && oam_we),
      .wr_addr (oam_waddr),
      .wr_data (val),
      .rd_en   (accept && oam_re),
      .rd_addr (oam_ptr_ff),
      .rd_data (oam_rdata)
   );

   prsu_ram #(.WIDTH(8), .DEPTH(prsu_pkg::PAL_DEPTH)) u_pal_ram (
      .clock   (clock),
      .wr_en   (accept && pal_we),
      .wr_addr (pal_slot),
      .wr_data (val),
      .rd_en   (accept && pal_re),
      .rd_addr (pal_slot),
      .rd_data (pal_rdata)
   );

   // Merge RAM data into the result and advance the pipeline
   always_comb begin
      out_in = s1_ff.rsp;
      case (s1_ff.rd_sel)
         prsu_pkg::RD_OAM: begin
            out_in.read_data = oam_rdata;
         end
         prsu_pkg::RD_PAL: begin
            out_in.read_data = s1_ff.gray ? (pal_rdata & prsu_pkg::GRAY_MASK) : pal_rdata;
         end
         default: begin
         end
      endcase

      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end

      if (s1_move) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // Control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nmi_enable_ff <= 1'b0;
         step32_ff     <= 1'b0;
         bg_sel_ff     <= 1'b0;
         spr_sel_ff    <= 1'b0;
         tall_ff       <= 1'b0;
         mask_ff       <= '0;
         temp_ff       <= '0;
         cur_ff        <= '0;
         fine_x_ff     <= '0;
         toggle_ff     <= 1'b0;
         vblank_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         oam_ptr_ff    <= '0;
         rbuf_ff       <= '0;
         s1_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         if (accept) begin
            nmi_enable_ff <= nmi_enable_in;
            step32_ff     <= step32_in;
            bg_sel_ff     <= bg_sel_in;
            spr_sel_ff    <= spr_sel_in;
            tall_ff       <= tall_in;
            mask_ff       <= mask_in;
            temp_ff       <= temp_in;
            cur_ff        <= cur_in;
            fine_x_ff     <= fine_x_in;
            toggle_ff     <= toggle_in;
            vblank_ff     <= vblank_in;
            hit_ff        <= hit_in;
            ovf_ff        <= ovf_in;
            oam_ptr_ff    <= oam_ptr_in;
            rbuf_ff       <= rbuf_in;
         end
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_ff};

endmodule

// ===== sv/prsu_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module prsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, then registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/prsu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the picture-unit register and scroll unit.
// Depends on ppu_register_scroll_unit_top; bound to it below.

module prsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Input back-pressure only when the result side is blocked
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

   // Memory read and write requests are exclusive
   a_req_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[10]))
      else $error("read and write requested together");

   // Keep the address at zero when no request is made
   a_addr_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] && !rsp_tdata[10] |-> rsp_tdata[24:11] == 14'd0)
      else $error("address without request");

   // Write byte only with a write request
   a_wdata_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[10] |-> rsp_tdata[32:25] == 8'd0)
      else $error("write byte without write request");

endmodule

bind ppu_register_scroll_unit_top prsu_checker u_prsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
